// ===== hw/rtl/pwc_pkg.sv =====
package pwc_pkg;

   localparam int MAX_SEGMENTS_DEFAULT    = 16;
   localparam int COORD_FRAC_BITS_DEFAULT = 16;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_COLLIDE = 1'b1;

   localparam logic [2:0] WORD_START_X   = 3'd0;
   localparam logic [2:0] WORD_START_Y   = 3'd1;
   localparam logic [2:0] WORD_NORMAL_X  = 3'd2;
   localparam logic [2:0] WORD_NORMAL_Y  = 3'd3;
   localparam logic [2:0] WORD_TANGENT_X = 3'd4;
   localparam logic [2:0] WORD_TANGENT_Y = 3'd5;
   localparam logic [2:0] WORD_LENGTH_SQ = 3'd6;
   localparam logic [2:0] WORD_RESERVED  = 3'd7;

   localparam logic CSR_SEGMENT_COUNT    = 1'b0;
   localparam logic CSR_COLLISION_RADIUS = 1'b1;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] tangent_x;
      logic signed [31:0] tangent_y;
      logic signed [63:0] length_sq;
   } seg_type;

   typedef struct packed {
      logic        rotate;
      logic        wr_en;
      logic [3:0]  wr_index;
      logic [2:0]  wr_sel;
      logic [63:0] wr_value;
   } ring_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DN, ST_DOLD, ST_S1, ST_S2, ST_CHK, ST_DIV, ST_MULC,
      ST_CX, ST_E, ST_D2, ST_DT, ST_RES, ST_NEXT, ST_DRAIN, ST_DONE
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sdiff(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      return sat32(68'(a) - 68'(b));
   endfunction

   function automatic logic signed [67:0] shr_trunc(input logic signed [67:0] v,
                                                    input logic [6:0] s);
      logic [67:0] mag;
      mag = v[67] ? 68'(-v) : 68'(v);
      mag = mag >> s;
      return v[67] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

// ===== hw/rtl/pwc_req_if.sv =====
interface pwc_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [3:0]         seg_index;
   logic [2:0]         word_select;
   logic signed [63:0] word_value;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] prev_x;
   logic signed [31:0] prev_y;

   modport source (output valid, operation, seg_index, word_select, word_value,
                    pos_x, pos_y, prev_x, prev_y, input ready);
   modport sink (input valid, operation, seg_index, word_select, word_value,
                 pos_x, pos_y, prev_x, prev_y, output ready);
endinterface

// ===== hw/rtl/pwc_rsp_if.sv =====
interface pwc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;
   logic               hit;
   logic [3:0]         hit_segment;

   modport source (output valid, new_x, new_y, hit, hit_segment, input ready);
   modport sink (input valid, new_x, new_y, hit, hit_segment, output ready);
endinterface

// ===== hw/rtl/particle_wall_collision_2d_core.sv =====
// Particle against wall segment collision core.
// req carries table write words and collide words; rsp returns one word per
// collide word (new_x, new_y, hit, hit_segment). A write word updates one
// entry of the segment ring and returns nothing.
// csr_write_enable/csr_index/csr_write_data set the segment count and the
// collision radius; write them only while the core is idle.
// Segments live in a ring of cells; cell 0 feeds a sequential arithmetic
// engine with two 34x34 multipliers. The crossing fraction, when needed, is
// found by a bit-serial divider. After a hit or the last active segment,
// the ring rotates until it has turned through MAX_SEGMENTS cells. A
// collide word with no active segment goes straight to its result.
// One collide word is worked at a time; req is ready only when idle.
// The result waits in an output register; a stalled rsp holds it and the
// next collide word may be taken meanwhile, its result held until the
// first is taken.
// Reset clears control state, segment_count to 0 and collision_radius to
// 1.0; the segment table holds no defined content until written.
module particle_wall_collision_2d_core #(
   parameter int MAX_SEGMENTS    = pwc_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int COORD_FRAC_BITS = pwc_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   pwc_req_if.sink     req,
   pwc_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [30:0] csr_write_data
);

   logic [4:0]  count_ff;
   logic [30:0] radius_ff;
   pwc_pkg::ring_ctrl_type ctrl;
   pwc_pkg::seg_type       seg [MAX_SEGMENTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         radius_ff <= 31'd65536;
      end else if (csr_write_enable) begin
         case (csr_index)
            pwc_pkg::CSR_SEGMENT_COUNT:    count_ff  <= csr_write_data[4:0];
            pwc_pkg::CSR_COLLISION_RADIUS: radius_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
      pwc_cell #(.INDEX(k)) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .seg_next (seg[(k + 1) % MAX_SEGMENTS]),
         .seg      (seg[k])
      );
   end

   pwc_engine #(
      .MAX_SEGMENTS    (MAX_SEGMENTS),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .segment_count    (count_ff),
      .collision_radius (radius_ff),
      .head             (seg[0]),
      .ctrl             (ctrl)
   );

endmodule

// ===== hw/rtl/pwc_cell.sv =====
module pwc_cell #(
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  pwc_pkg::ring_ctrl_type ctrl,
   input  pwc_pkg::seg_type       seg_next,
   output pwc_pkg::seg_type       seg
);

   pwc_pkg::seg_type seg_ff;
   pwc_pkg::seg_type seg_in;
   logic             match;

   assign match = ctrl.wr_en && (9'(ctrl.wr_index) == 9'(INDEX));

   always_comb begin
      seg_in = seg_ff;
      if (ctrl.rotate) begin
         seg_in = seg_next;
      end else if (match) begin
         case (ctrl.wr_sel)
            pwc_pkg::WORD_START_X:   seg_in.start_x   = ctrl.wr_value[31:0];
            pwc_pkg::WORD_START_Y:   seg_in.start_y   = ctrl.wr_value[31:0];
            pwc_pkg::WORD_NORMAL_X:  seg_in.normal_x  = ctrl.wr_value[31:0];
            pwc_pkg::WORD_NORMAL_Y:  seg_in.normal_y  = ctrl.wr_value[31:0];
            pwc_pkg::WORD_TANGENT_X: seg_in.tangent_x = ctrl.wr_value[31:0];
            pwc_pkg::WORD_TANGENT_Y: seg_in.tangent_y = ctrl.wr_value[31:0];
            pwc_pkg::WORD_LENGTH_SQ: seg_in.length_sq = ctrl.wr_value;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   assign seg = seg_ff;

endmodule

// ===== hw/rtl/pwc_engine.sv =====
module pwc_engine #(
   parameter int MAX_SEGMENTS    = pwc_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int COORD_FRAC_BITS = pwc_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   pwc_req_if.sink                req,
   pwc_rsp_if.source              rsp,
   input  logic [4:0]             segment_count,
   input  logic [30:0]            collision_radius,
   input  pwc_pkg::seg_type       head,
   output pwc_pkg::ring_ctrl_type ctrl
);

   localparam int RW = $clog2(MAX_SEGMENTS + 1);
   localparam int NW = (RW > 5) ? RW : 5;

   pwc_pkg::state_type state_ff, state_in;
   logic [RW-1:0] rot_ff, rot_in, cnt_ff, cnt_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, ox_ff, ox_in, oy_ff, oy_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic signed [31:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [63:0] dn_ff, dn_in, dold_ff, dold_in, s1_ff, s1_in, s2_ff, s2_in;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [4:0]  div_ff, div_in;
   logic [32:0] t_ff, t_in;
   logic        hit_ff, hit_in;
   logic [3:0]  hseg_ff, hseg_in;
   logic signed [67:0] p0_ff, p1_ff, prod0, prod1;
   logic signed [33:0] ma0, mb0, ma1, mb1;
   logic signed [63:0] sum;
   logic [63:0] usum, rem_sh;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic        rsp_hit_ff, rsp_hit_in;
   logic [3:0]  rsp_seg_ff, rsp_seg_in;
   logic [NW-1:0] n_eff;
   logic        accept;

   assign n_eff = (NW'(segment_count) > NW'(MAX_SEGMENTS)) ? NW'(MAX_SEGMENTS)
                                                          : NW'(segment_count);
   assign prod0  = ma0 * mb0;
   assign prod1  = ma1 * mb1;
   assign usum   = p0_ff[63:0] + p1_ff[63:0];
   assign sum    = $signed(usum);
   assign rem_sh = {rem_ff[62:0], 1'b0};
   assign accept = req.valid && req.ready;

   always_comb begin
      state_in = state_ff;
      rot_in = rot_ff;     cnt_in = cnt_ff;
      px_in = px_ff;       py_in = py_ff;     ox_in = ox_ff;   oy_in = oy_ff;
      cx_in = cx_ff;       cy_in = cy_ff;     ex_in = ex_ff;   ey_in = ey_ff;
      rx_in = rx_ff;       ry_in = ry_ff;
      dn_in = dn_ff;       dold_in = dold_ff; s1_in = s1_ff;   s2_in = s2_ff;
      rem_in = rem_ff;     quo_in = quo_ff;   div_in = div_ff; t_in = t_ff;
      hit_in = hit_ff;     hseg_in = hseg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_x_in = rsp_x_ff; rsp_y_in = rsp_y_ff;
      rsp_hit_in = rsp_hit_ff; rsp_seg_in = rsp_seg_ff;
      ma0 = '0; mb0 = '0; ma1 = '0; mb1 = '0;
      req.ready = (state_ff == pwc_pkg::ST_IDLE);
      ctrl.rotate   = 1'b0;
      ctrl.wr_en    = accept && (req.operation == pwc_pkg::OP_WRITE);
      ctrl.wr_index = req.seg_index;
      ctrl.wr_sel   = req.word_select;
      ctrl.wr_value = req.word_value;

      case (state_ff)
         pwc_pkg::ST_IDLE: begin
            if (accept && req.operation == pwc_pkg::OP_COLLIDE) begin
               px_in = req.pos_x;  py_in = req.pos_y;
               ox_in = req.prev_x; oy_in = req.prev_y;
               rx_in = req.pos_x;  ry_in = req.pos_y;
               hit_in = 1'b0; hseg_in = '0; rot_in = '0;
               cnt_in = RW'(n_eff);
               state_in = (n_eff == '0) ? pwc_pkg::ST_DONE : pwc_pkg::ST_DN;
            end
         end
         pwc_pkg::ST_DN: begin
            ma0 = 34'(pwc_pkg::sdiff(px_ff, head.start_x)); mb0 = 34'(head.normal_x);
            ma1 = 34'(pwc_pkg::sdiff(py_ff, head.start_y)); mb1 = 34'(head.normal_y);
            state_in = pwc_pkg::ST_DOLD;
         end
         pwc_pkg::ST_DOLD: begin
            dn_in = sum;
            ma0 = 34'(pwc_pkg::sdiff(ox_ff, head.start_x)); mb0 = 34'(head.normal_x);
            ma1 = 34'(pwc_pkg::sdiff(oy_ff, head.start_y)); mb1 = 34'(head.normal_y);
            state_in = pwc_pkg::ST_S1;
         end
         pwc_pkg::ST_S1: begin
            dold_in = sum;
            ma0 = 34'(pwc_pkg::sdiff(head.start_x, ox_ff)); mb0 = 34'(head.normal_x);
            ma1 = 34'(pwc_pkg::sdiff(head.start_y, oy_ff)); mb1 = 34'(head.normal_y);
            state_in = pwc_pkg::ST_S2;
         end
         pwc_pkg::ST_S2: begin
            s1_in = sum;
            ma0 = 34'(pwc_pkg::sdiff(px_ff, ox_ff)); mb0 = 34'(head.normal_x);
            ma1 = 34'(pwc_pkg::sdiff(py_ff, oy_ff)); mb1 = 34'(head.normal_y);
            if ((dn_ff > 0 && dold_ff > 0) || (dn_ff < 0 && dold_ff < 0) || sum < 0) begin
               state_in = pwc_pkg::ST_NEXT;
            end else begin
               state_in = pwc_pkg::ST_CHK;
            end
         end
         pwc_pkg::ST_CHK: begin
            s2_in = sum;
            if (sum > 0) begin
               if (s1_ff >= sum) begin
                  t_in = 33'h1_0000_0000;
                  state_in = pwc_pkg::ST_MULC;
               end else begin
                  rem_in = s1_ff; quo_in = '0; div_in = '0;
                  state_in = pwc_pkg::ST_DIV;
               end
            end else begin
               cx_in = ox_ff; cy_in = oy_ff;
               state_in = pwc_pkg::ST_E;
            end
         end
         pwc_pkg::ST_DIV: begin
            if (rem_sh >= s2_ff) begin
               rem_in = rem_sh - s2_ff;
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[30:0], 1'b0};
            end
            div_in = div_ff + 5'd1;
            if (div_ff == 5'd31) begin
               t_in = {1'b0, quo_in};
               state_in = pwc_pkg::ST_MULC;
            end
         end
         pwc_pkg::ST_MULC: begin
            ma0 = 34'(pwc_pkg::sdiff(px_ff, ox_ff)); mb0 = $signed({1'b0, t_ff});
            ma1 = 34'(pwc_pkg::sdiff(py_ff, oy_ff)); mb1 = $signed({1'b0, t_ff});
            state_in = pwc_pkg::ST_CX;
         end
         pwc_pkg::ST_CX: begin
            cx_in = pwc_pkg::sat32(68'(ox_ff) + pwc_pkg::shr_trunc(p0_ff, 7'd32));
            cy_in = pwc_pkg::sat32(68'(oy_ff) + pwc_pkg::shr_trunc(p1_ff, 7'd32));
            state_in = pwc_pkg::ST_E;
         end
         pwc_pkg::ST_E: begin
            ex_in = pwc_pkg::sdiff(cx_ff, head.start_x);
            ey_in = pwc_pkg::sdiff(cy_ff, head.start_y);
            ma0 = 34'(ex_in); mb0 = 34'(ex_in);
            ma1 = 34'(ey_in); mb1 = 34'(ey_in);
            state_in = pwc_pkg::ST_D2;
         end
         pwc_pkg::ST_D2: begin
            ma0 = 34'(ex_ff); mb0 = 34'(head.tangent_x);
            ma1 = 34'(ey_ff); mb1 = 34'(head.tangent_y);
            if (head.length_sq[63] || usum > head.length_sq) begin
               state_in = pwc_pkg::ST_NEXT;
            end else begin
               state_in = pwc_pkg::ST_DT;
            end
         end
         pwc_pkg::ST_DT: begin
            ma0 = $signed({3'b000, collision_radius}); mb0 = 34'(head.normal_x);
            ma1 = $signed({3'b000, collision_radius}); mb1 = 34'(head.normal_y);
            state_in = (sum < 0) ? pwc_pkg::ST_NEXT : pwc_pkg::ST_RES;
         end
         pwc_pkg::ST_RES: begin
            rx_in = pwc_pkg::sat32(68'(cx_ff) -
                                   pwc_pkg::shr_trunc(p0_ff, 7'(COORD_FRAC_BITS)));
            ry_in = pwc_pkg::sat32(68'(cy_ff) -
                                   pwc_pkg::shr_trunc(p1_ff, 7'(COORD_FRAC_BITS)));
            hit_in = 1'b1;
            hseg_in = 4'(rot_ff);
            state_in = pwc_pkg::ST_DRAIN;
         end
         pwc_pkg::ST_NEXT: begin
            ctrl.rotate = 1'b1;
            rot_in = rot_ff + 1'b1;
            state_in = (rot_in < cnt_ff) ? pwc_pkg::ST_DN : pwc_pkg::ST_DRAIN;
         end
         pwc_pkg::ST_DRAIN: begin
            if (rot_ff == RW'(MAX_SEGMENTS)) begin
               state_in = pwc_pkg::ST_DONE;
            end else begin
               ctrl.rotate = 1'b1;
               rot_in = rot_ff + 1'b1;
            end
         end
         pwc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = rx_ff;  rsp_y_in = ry_ff;
               rsp_hit_in = hit_ff; rsp_seg_in = hseg_ff;
               state_in = pwc_pkg::ST_IDLE;
            end
         end
         default: state_in = pwc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rot_ff       <= '0;
         div_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rot_ff       <= rot_in;
         div_ff       <= div_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      px_ff <= px_in;   py_ff <= py_in;   ox_ff <= ox_in;   oy_ff <= oy_in;
      cx_ff <= cx_in;   cy_ff <= cy_in;   ex_ff <= ex_in;   ey_ff <= ey_in;
      rx_ff <= rx_in;   ry_ff <= ry_in;
      dn_ff <= dn_in;   dold_ff <= dold_in; s1_ff <= s1_in; s2_ff <= s2_in;
      rem_ff <= rem_in; quo_ff <= quo_in; t_ff <= t_in;
      hit_ff <= hit_in; hseg_ff <= hseg_in;
      p0_ff <= prod0;   p1_ff <= prod1;
      rsp_x_ff <= rsp_x_in; rsp_y_ff <= rsp_y_in;
      rsp_hit_ff <= rsp_hit_in; rsp_seg_ff <= rsp_seg_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.new_x       = rsp_x_ff;
   assign rsp.new_y       = rsp_y_ff;
   assign rsp.hit         = rsp_hit_ff;
   assign rsp.hit_segment = rsp_seg_ff;

endmodule
